>>> hw/rtl/ln_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_pkg
// shared constants, command and status types for the layer norm block
// ----------------------------------------------------------------------------
package ln_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int DATA_W      = 16;
  localparam int INV_W       = 24;
  localparam int DIVR_W      = 33;
  localparam int RECIP_SHIFT = 48;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_VAR  = 2'd1,
    DIV_INV  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     emit_cap;
    logic     div_start;
    div_sel_t div_sel;
    logic     sweep_rd;
    logic     sqrt_start;
    logic     emit_rd;
    logic     mul1;
    logic     mul2;
    logic     emit_fin;
    logic     nodata_fin;
  } ln_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic sweep_end;
    logic pipe_idle;
    logic emit_last;
    logic out_free;
  } ln_sts_t;

endpackage

>>> hw/rtl/ln_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_in_if
// request channel into the layer norm block
// ----------------------------------------------------------------------------
interface ln_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] value;
  logic signed [15:0] gain;
  logic signed [15:0] bias;
  logic               last;

  modport source (output valid, action, value, gain, bias, last, input ready);
  modport sink   (input valid, action, value, gain, bias, last, output ready);
endinterface

>>> hw/rtl/ln_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_out_if
// result channel out of the layer norm block
// ----------------------------------------------------------------------------
interface ln_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y;
  logic               last_out;
  logic               no_data;

  modport source (output valid, y, last_out, no_data, input ready);
  modport sink   (input valid, y, last_out, no_data, output ready);
endinterface

>>> hw/rtl/ln_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ln_div #(
  parameter int DW = 49,
  parameter int VW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   r2;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    r2   = {rem, q[DW-1]};
    diff = r2 - {1'b0, dvs};
    ge   = (r2 >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= dividend;
        dvs <= divisor;
        rem <= '0;
        cnt <= CW'(DW);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[VW-1:0] : r2[VW-1:0];
        q   <= {q[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;
endmodule

>>> hw/rtl/ln_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ln_sqrt #(
  parameter int W = 49
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] din,
  output logic         done,
  output logic [W-1:0] root
);
  localparam int TOP = ((W - 1) / 2) * 2;

  logic [W-1:0] v;
  logic [W-1:0] res;
  logic [W-1:0] bt;
  logic         run;
  logic [W:0]   sum;
  logic         ge;

  always_comb begin
    sum = {1'b0, res} + {1'b0, bt};
    ge  = ({1'b0, v} >= sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v   <= din;
        res <= '0;
        bt  <= W'(1) << TOP;
        run <= 1'b1;
      end else if (run) begin
        if (ge) begin
          v   <= v - sum[W-1:0];
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt <= bt >> 2;
        if (bt[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res;
endmodule

>>> hw/rtl/ln_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_ctrl
// sequencer for loads, the closing pass and emits
// ----------------------------------------------------------------------------
module ln_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_action,
  input  logic            in_last,
  output logic            in_ready,
  input  ln_pkg::ln_sts_t sts,
  output ln_pkg::ln_cmd_t cmd
);
  import ln_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MEAN_GO   = 13'b0000000000010,
    S_MEAN_WAIT = 13'b0000000000100,
    S_SWEEP     = 13'b0000000001000,
    S_DRAIN     = 13'b0000000010000,
    S_VAR_WAIT  = 13'b0000000100000,
    S_INV_GO    = 13'b0000001000000,
    S_INV_WAIT  = 13'b0000010000000,
    S_SQRT_WAIT = 13'b0000100000000,
    S_RD        = 13'b0001000000000,
    S_MUL1      = 13'b0010000000000,
    S_MUL2      = 13'b0100000000000,
    S_FIN       = 13'b1000000000000
  } state_t;

  // no-data reply shares the final state, marked by nd
  state_t state, state_next;
  logic   vec_ready, vec_ready_next;
  logic   closed, closed_next;
  logic   nd, nd_next;

  always_comb begin
    state_next     = state;
    vec_ready_next = vec_ready;
    closed_next    = closed;
    nd_next        = nd;
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_action) begin
            cmd.load  = 1'b1;
            cmd.clear = closed;
            if (closed) begin
              closed_next    = 1'b0;
              vec_ready_next = 1'b0;
            end
            if (in_last) begin
              closed_next = 1'b1;
              state_next  = S_MEAN_GO;
            end
          end else begin
            cmd.emit_cap = 1'b1;
            nd_next      = !vec_ready;
            state_next   = vec_ready ? S_RD : S_FIN;
          end
        end
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: if (sts.div_done) state_next = S_SWEEP;
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (sts.sweep_end) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.pipe_idle) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_VAR;
          state_next    = S_VAR_WAIT;
        end
      end
      S_VAR_WAIT: if (sts.div_done) state_next = S_INV_GO;
      S_INV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INV;
        state_next    = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          vec_ready_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          if (nd) begin
            cmd.nodata_fin = 1'b1;
          end else begin
            cmd.emit_fin = 1'b1;
            if (sts.emit_last) vec_ready_next = 1'b0;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vec_ready <= 1'b0;
      closed    <= 1'b0;
      nd        <= 1'b0;
    end else begin
      state     <= state_next;
      vec_ready <= vec_ready_next;
      closed    <= closed_next;
      nd        <= nd_next;
    end
  end
endmodule

>>> hw/rtl/ln_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_datapath
// element store, statistics, divider, root and emit arithmetic
// ----------------------------------------------------------------------------
module ln_datapath #(
  parameter int MAX_LEN = ln_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ln_pkg::ln_cmd_t               cmd,
  output ln_pkg::ln_sts_t               sts,
  input  logic signed [ln_pkg::DATA_W-1:0] value,
  input  logic signed [ln_pkg::DATA_W-1:0] gain,
  input  logic signed [ln_pkg::DATA_W-1:0] bias,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ln_pkg::DATA_W-1:0] y,
  output logic                          last_out,
  output logic                          no_data
);
  import ln_pkg::*;

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int SQW   = 2 * DATA_W + CNT_W;
  localparam int DW    = (SQW > RECIP_SHIFT + 1) ? SQW : RECIP_SHIFT + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
  localparam logic [INV_W-1:0] INV_MAX = '1;

  logic [DATA_W-1:0] mem [MAX_LEN];
  logic signed [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;

  logic [CNT_W-1:0]        count, cnt_base, emit_idx;
  logic [AW-1:0]           sweep_idx;
  logic signed [SUM_W-1:0] sum, sum_base;
  logic signed [DATA_W-1:0] mean;
  logic [INV_W-1:0]        inv;
  logic [SQW-1:0]          sumsq;
  logic [DIVR_W-1:0]       var_p1;
  logic [31:0]             sq;
  logic                    v1, v2;
  logic                    wr_en;

  logic signed [DATA_W-1:0] g_reg, b_reg;
  logic signed [DATA_W:0]   d;
  logic signed [33:0]       dsq;
  logic signed [41:0]       m1;
  logic signed [40:0]       pl_p;
  logic signed [33:0]       ph_p;
  logic signed [40:0]       t_rnd;
  logic signed [35:0]       ysum;
  logic signed [DATA_W-1:0] y_sat;

  div_sel_t                sel_q;
  logic signed [DW:0]      num_s;
  logic [DW-1:0]           div_a;
  logic [DIVR_W-1:0]       div_b;
  logic                    div_done, sqrt_done;
  logic [DW-1:0]           div_q, root;

  // load path and store read port
  always_comb begin
    cnt_base = cmd.clear ? '0 : count;
    sum_base = cmd.clear ? '0 : sum;
    wr_en    = cmd.load && (cnt_base < MAX_CNT);
    rd_addr  = cmd.sweep_rd ? sweep_idx : emit_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_base[AW-1:0]] <= value;
    if (cmd.sweep_rd || cmd.emit_rd) rd_data <= mem[rd_addr];
  end

  // divider operand select
  always_comb begin
    num_s = ((DW + 1)'(sum) <<< 1) + (DW + 1)'({count, 16'b0}) + (DW + 1)'(count);
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        div_a = num_s[DW-1:0];
        div_b = DIVR_W'({count, 1'b0});
      end
      DIV_VAR: begin
        div_a = DW'(sumsq);
        div_b = DIVR_W'(count);
      end
      DIV_INV: begin
        div_a = DW'(1) << RECIP_SHIFT;
        div_b = var_p1;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  ln_div #(.DW(DW), .VW(DIVR_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  ln_sqrt #(.W(DW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .din   (div_q),
    .done  (sqrt_done),
    .root  (root)
  );

  // arithmetic
  always_comb begin
    d     = (DATA_W + 1)'(rd_data) - (DATA_W + 1)'(mean);
    dsq   = d * d;
    t_rnd = pl_p + 41'sd8388608;
    ysum  = 36'(ph_p) + 36'(b_reg) + 36'(t_rnd >>> 24);
    if (ysum > 36'sd32767)       y_sat = 16'sh7fff;
    else if (ysum < -36'sd32768) y_sat = -16'sh8000;
    else                         y_sat = ysum[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_q <= cmd.div_sel;
    if (cmd.emit_cap) begin
      g_reg <= gain;
      b_reg <= bias;
    end
    sq <= dsq[31:0];
    if (cmd.mul1) m1 <= d * $signed({1'b0, inv});
    if (cmd.mul2) begin
      pl_p <= $signed({1'b0, m1[23:0]}) * g_reg;
      ph_p <= $signed(m1[41:24]) * g_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum       <= '0;
      emit_idx  <= '0;
      mean      <= '0;
      inv       <= '0;
      sumsq     <= '0;
      var_p1    <= '0;
      sweep_idx <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.sweep_rd;
      v2 <= v1;
      if (v2) sumsq <= sumsq + SQW'(sq);
      if (cmd.sweep_rd) sweep_idx <= sweep_idx + AW'(1);
      if (cmd.load) begin
        if (cmd.clear) begin
          count    <= '0;
          sum      <= '0;
          emit_idx <= '0;
        end
        if (wr_en) begin
          count <= cnt_base + CNT_W'(1);
          sum   <= sum_base + SUM_W'(value);
        end
      end
      if (div_done) begin
        unique case (sel_q)
          DIV_MEAN: begin
            mean      <= {~div_q[DATA_W-1], div_q[DATA_W-2:0]};
            sweep_idx <= '0;
            sumsq     <= '0;
          end
          DIV_VAR: var_p1 <= div_q[DIVR_W-1:0] + DIVR_W'(1);
          default: ;
        endcase
      end
      if (sqrt_done) begin
        inv      <= (root > DW'(INV_MAX)) ? INV_MAX : root[INV_W-1:0];
        emit_idx <= '0;
      end
      if (cmd.emit_fin) begin
        out_valid <= 1'b1;
        y         <= y_sat;
        last_out  <= sts.emit_last;
        no_data   <= 1'b0;
        emit_idx  <= emit_idx + CNT_W'(1);
      end else if (cmd.nodata_fin) begin
        out_valid <= 1'b1;
        y         <= '0;
        last_out  <= 1'b0;
        no_data   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.sweep_end = (CNT_W'(sweep_idx) + CNT_W'(1) == count);
    sts.pipe_idle = !v1 && !v2;
    sts.emit_last = (emit_idx + CNT_W'(1) >= count);
    sts.out_free  = !out_valid || out_ready;
  end
endmodule

>>> hw/rtl/layer_normalization.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_normalization
// layer norm of one q8.8 vector with per-element gain and bias
// ----------------------------------------------------------------------------
// use:
//   in_ch carries requests: action 0 loads value (last closes the vector),
//   action 1 emits the next normalised element using gain and bias
//   out_ch carries one result per emit request: y, last_out, no_data
//   a load returns nothing
//   a load with last starts the closing pass: mean divide, a sweep over
//   the stored elements, variance divide, reciprocal divide and the root;
//   the divides and the root work on DW-bit operands, DW being 49 at the
//   default length
//   an emit runs through a store read, two multiply stages, then the final
//   add and saturation into the output register
//   an emit with no vector left replies with no_data set
//   one request at a time: in_ch.ready is high only when the sequencer idles
//   the result sits in an output register, so the next request is taken
//   while it waits; if the receiver stalls a further emit holds in its last
//   stage until the register frees
//   synchronous reset clears the counters, flags and output valid; the
//   element store itself is not cleared and is only read where written
// ----------------------------------------------------------------------------
module layer_normalization #(
  parameter int MAX_LEN = ln_pkg::MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst,
  ln_in_if.sink    in_ch,
  ln_out_if.source out_ch
);
  import ln_pkg::*;

  ln_cmd_t cmd;
  ln_sts_t sts;

  // sequencer: one-hot state machine issuing datapath commands
  ln_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: store, sums, shared divider and root, emit pipeline
  ln_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (in_ch.value),
    .gain      (in_ch.gain),
    .bias      (in_ch.bias),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .y         (out_ch.y),
    .last_out  (out_ch.last_out),
    .no_data   (out_ch.no_data)
  );
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for layer_normalization: a directed table of requests,
// then random vectors, with every result checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb;
  import ln_pkg::*;

  localparam int LEN = MAX_LEN_DEF;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ln_in_if  req_if ();
  ln_out_if res_if ();

  layer_normalization dut (.clk(clk), .rst(rst), .in_ch(req_if.sink), .out_ch(res_if.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic               act;
    logic signed [15:0] val;
    logic signed [15:0] g;
    logic signed [15:0] b;
    logic               lst;
  } req_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic               lo;
    logic               nd;
  } norm_t;

  // directed row: request plus optional hand-typed result
  typedef struct packed {
    req_t  r;
    logic  typed;
    norm_t want;
  } row_t;

  // predictor state
  logic [15:0]        elem_mem [LEN];
  longint             acc_sum;
  int                 n_elem;
  int                 next_idx;
  longint             mean_q;
  longint             inv_dev;
  bit                 vec_open;
  bit                 closed;

  norm_t  pending_norm [$];
  int     errors = 0;
  int     n_results = 0;
  int     n_loads = 0;
  int     n_emits = 0;
  int     n_vectors = 0;
  int     idle_cycles = 0;

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, bitv;
    r = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // mean, two-pass variance and inverse deviation of the closed vector
  task automatic close_stats();
    longint sq, d, v, rt;
    sq = 0;
    mean_q = fdiv(2 * acc_sum + n_elem, 2 * n_elem);
    for (int i = 0; i < n_elem; i++) begin
      d = longint'($signed(elem_mem[i])) - mean_q;
      sq += d * d;
    end
    v = sq / n_elem + 1;
    rt = root_floor((longint'(1) << 48) / v);
    inv_dev = (rt > 64'hFFFFFF) ? 64'hFFFFFF : rt;
    next_idx = 0;
    vec_open = 1'b1;
    n_vectors++;
  endtask

  // apply one accepted request; emits queue their expected result
  task automatic predict_norm(input req_t r);
    norm_t o;
    longint d, a, yy;
    if (!r.act) begin
      n_loads++;
      if (vec_open || closed) begin
        acc_sum = 0; n_elem = 0; next_idx = 0;
        vec_open = 1'b0; closed = 1'b0;
      end
      if (n_elem < LEN) begin
        elem_mem[n_elem] = r.val;
        acc_sum += longint'(r.val);
        n_elem++;
      end
      if (r.lst) begin
        closed = 1'b1;
        close_stats();
      end
      return;
    end
    n_emits++;
    if (!vec_open) begin
      o = '{y: 16'sd0, lo: 1'b0, nd: 1'b1};
    end else begin
      d = longint'($signed(elem_mem[next_idx])) - mean_q;
      a = d * inv_dev * longint'(r.g) + longint'(r.b) * (longint'(1) << 24);
      yy = fdiv(a + (longint'(1) << 23), longint'(1) << 24);
      if (yy > 32767) yy = 32767;
      if (yy < -32768) yy = -32768;
      next_idx++;
      o.y  = yy[15:0];
      o.lo = (next_idx >= n_elem);
      o.nd = 1'b0;
      if (next_idx >= n_elem) vec_open = 1'b0;
    end
    pending_norm.push_back(o);
  endtask

  // sender side
  req_t   send_q [$];
  bit     send_done = 1'b0;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = 1'b0;
    req_if.value = '0;
    req_if.gain = '0;
    req_if.bias = '0;
    req_if.last = 1'b0;
    res_if.ready = 1'b0;
  end

  // directed table, walked in order; typed rows carry their result
  row_t table_rows [$];
  norm_t typed_q [$];
  int typed_at [$];

  function automatic req_t mk(int a, int v, int g, int b, int l);
    req_t r;
    r.act = 1'(a); r.val = 16'(v); r.g = 16'(g); r.b = 16'(b); r.lst = 1'(l);
    return r;
  endfunction

  task automatic add_row(input req_t r, input int t, input norm_t w);
    row_t rw;
    rw.r = r; rw.typed = (t != 0); rw.want = w;
    table_rows.push_back(rw);
  endtask

  task automatic build_table();
    norm_t nd0, none;
    nd0 = '{y: 16'sd0, lo: 1'b0, nd: 1'b1};
    none = '0;
    // emit straight after reset has nothing to work on
    add_row(mk(1, 0, 16'h7fff, 16'h7fff, 0), 1, nd0);
    // two-element vector at the field extremes
    add_row(mk(0, -32768, 0, 0, 0), 0, none);
    add_row(mk(0, 32767, 0, 0, 1), 0, none);
    add_row(mk(1, 0, 32767, -32768, 0), 0, none);
    add_row(mk(1, 0, -32768, 32767, 0), 0, none);
    // vector exhausted
    add_row(mk(1, 0, 256, 0, 0), 1, nd0);
    // constant vector: zero variance, inverse saturates; gain 0 gives bias
    add_row(mk(0, 100, 0, 0, 0), 0, none);
    add_row(mk(0, 100, 0, 0, 0), 0, none);
    add_row(mk(0, 100, 0, 0, 1), 0, none);
    add_row(mk(1, 0, 0, 16'sd1234, 0), 1, '{y: 16'sd1234, lo: 1'b0, nd: 1'b0});
    add_row(mk(1, 0, 32767, 32767, 0), 0, none);
    // load over a partly emitted vector drops the rest
    add_row(mk(0, -1, 0, 0, 0), 0, none);
    add_row(mk(0, 1, 0, 0, 1), 0, none);
    add_row(mk(1, 0, 256, 0, 0), 0, none);
    // single-element vector
    add_row(mk(0, 16'sh5555, 0, 0, 1), 0, none);
    add_row(mk(1, 0, 256, -1, 0), 0, none);
    add_row(mk(1, 0, 256, 0, 0), 1, nd0);
    add_row(mk(0, 16'shaaaa, 0, 0, 0), 0, none);
    add_row(mk(0, 0, 0, 0, 1), 0, none);
    add_row(mk(1, 0, 16'shaaaa, 16'sh5555, 0), 0, none);
    add_row(mk(1, 0, 16'sh5555, 16'shaaaa, 0), 0, none);
  endtask

  function automatic req_t rnd_emit();
    return mk(1, $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1023),
              $urandom, $urandom);
  endfunction

  function automatic int rnd_val(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 511) - 256;
      default: return 2000 + $urandom_range(0, 15);
    endcase
  endfunction

  // drive one request at the falling edge and hold it until taken
  task automatic send_req(input req_t r);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= r.act;
    req_if.value  <= r.val;
    req_if.gain   <= r.g;
    req_if.bias   <= r.b;
    req_if.last   <= r.lst;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // accepted requests feed the predictor at the sampling edge
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      predict_norm('{act: req_if.action, val: req_if.value, g: req_if.gain,
                     b: req_if.bias, lst: req_if.last});
    end
  end

  // result check against the oldest expectation, typed rows checked as well
  always @(posedge clk) begin
    norm_t w;
    if (!rst && res_if.valid && res_if.ready) begin
      n_results++;
      if (pending_norm.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result y=%0d", res_if.y);
      end else begin
        w = pending_norm.pop_front();
        if (w.y !== res_if.y || w.lo !== res_if.last_out || w.nd !== res_if.no_data) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: want y=%0d last=%0b nd=%0b got y=%0d last=%0b nd=%0b",
                     n_results, w.y, w.lo, w.nd, res_if.y, res_if.last_out, res_if.no_data);
        end
      end
      if (typed_at.size() > 0 && typed_at[0] == n_results - 1) begin
        if (typed_q[0].y !== res_if.y || typed_q[0].lo !== res_if.last_out ||
            typed_q[0].nd !== res_if.no_data) begin
          errors++;
          if (errors <= 10)
            $display("directed result %0d: want y=%0d last=%0b nd=%0b got y=%0d last=%0b nd=%0b",
                     typed_at[0], typed_q[0].y, typed_q[0].lo, typed_q[0].nd,
                     res_if.y, res_if.last_out, res_if.no_data);
        end
        void'(typed_at.pop_front());
        void'(typed_q.pop_front());
      end
    end
  end

  // receiver: random stalls, ready often held low between results
  initial begin
    int k;
    @(negedge clk);
    while (1) begin
      k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (k != 0) begin
        res_if.ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int emit_seen, len, style;
    emit_seen = 0;
    acc_sum = 0; n_elem = 0; next_idx = 0; mean_q = 0; inv_dev = 0;
    vec_open = 0; closed = 0;
    build_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed part
    foreach (table_rows[i]) begin
      if (table_rows[i].r.act) begin
        emit_seen++;
        if (table_rows[i].typed) begin
          typed_at.push_back(emit_seen - 1);
          typed_q.push_back(table_rows[i].want);
        end
      end
      send_req(table_rows[i].r);
    end
    // pause until every result is back
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_norm.size() != 0) @(negedge clk);
    // random vectors, mostly full load-then-emit sequences
    for (int it = 0; it < 1050;) begin
      case ($urandom_range(0, 9))
        0: begin
          send_req(rnd_emit()); it++;
        end
        1: begin
          send_req(mk(0, $urandom, $urandom, $urandom, $urandom)); it++;
        end
        default: begin
          len = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
          style = $urandom_range(0, 2);
          for (int j = 0; j < len; j++) begin
            send_req(mk(0, rnd_val(style), $urandom, $urandom, j == len - 1)); it++;
          end
          for (int j = 0; j < len + $urandom_range(0, 2) - 1; j++) begin
            send_req(rnd_emit()); it++;
          end
        end
      endcase
    end
    req_if.valid <= 1'b0;
    send_done = 1'b1;
  end

  // end of run: stimulus accepted, queue drained, then a short tail; or the watchdog fires
  initial begin
    wait (!rst);
    fork
      begin
        wait (send_done && pending_norm.size() == 0);
        repeat (400) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("watchdog expired, %0d results outstanding", pending_norm.size());
        $display("layer_normalization: mismatch");
        $finish;
      end
    join_any
    $display("covered %0d loads, %0d emits, %0d closed vectors", n_loads, n_emits, n_vectors);
    $display("%0d results checked, %0d mismatches", n_results, errors);
    if (errors == 0 && pending_norm.size() == 0) begin
      $display("layer_normalization: match");
    end else begin
      $display("layer_normalization: mismatch");
    end
    $finish;
  end
endmodule

>>> layer_normalization.f
hw/rtl/ln_pkg.sv
hw/rtl/ln_in_if.sv
hw/rtl/ln_out_if.sv
hw/rtl/ln_div.sv
hw/rtl/ln_sqrt.sv
hw/rtl/ln_ctrl.sv
hw/rtl/ln_datapath.sv
hw/rtl/layer_normalization.sv
dv/tb.sv
